// ===== rtl/core/sdld_pkg.sv =====
// Constants and types shared by the log deframer.
// Record layout, status codes and register indexes; no dependencies.
`default_nettype none

package sdld_pkg;

    typedef logic [1:0] t_cfg_index;
    typedef logic [1:0] t_fmt_status;

    // configuration register indexes
    localparam t_cfg_index CFG_SYNC_FIRST       = 2'd0;
    localparam t_cfg_index CFG_SYNC_SECOND      = 2'd1;
    localparam t_cfg_index CFG_FORMAT_RECORD_ID = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RESET       = 8'd163;
    localparam logic [7:0] SYNC_SECOND_RESET      = 8'd149;
    localparam logic [7:0] FORMAT_RECORD_ID_RESET = 8'd128;

    // format status reported on the last beat of a format record
    localparam t_fmt_status STATUS_NONE     = 2'd0;
    localparam t_fmt_status STATUS_STORED   = 2'd1;
    localparam t_fmt_status STATUS_REJECTED = 2'd2;

    // format record layout (payload offsets)
    localparam logic [7:0] FORMAT_RECORD_BYTES = 8'd86;
    localparam logic [7:0] POS_TYPE            = 8'd0;
    localparam logic [7:0] POS_LENGTH          = 8'd1;
    localparam int         SPEC_CHARS          = 16;
    localparam int         LABEL_CHARS         = 64;
    localparam logic [7:0] SPEC_START          = 8'd6;
    localparam logic [7:0] LABEL_START         = 8'(6 + SPEC_CHARS);
    localparam logic [7:0] LABEL_END           = 8'(6 + SPEC_CHARS + LABEL_CHARS);

    localparam logic [7:0] CHAR_COMMA    = 8'h2C;
    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [4:0] SPEC_CNT_MAX  = 5'd31;
    localparam logic [5:0] LABEL_CNT_MAX = 6'd63;

endpackage

`default_nettype wire

// ===== rtl/core/self_describing_log_deframer_unit.sv =====
// Log record deframer: header hunt, id lookup, payload delivery, format learning.
// Uses sdld_pkg for layout constants and status codes.
//
// A payload beat goes from the edge that accepts it into the staging register, then
// the output register; an output stall holds it there. Throughput: one byte per cycle when
// the output does not stall; the length table is read at the accepted byte's address.
// Reset clears the phase, counters and the per-entry known bits at once; the length
// memory is not cleared, so the block takes bytes right after reset.
`default_nettype none

module self_describing_log_deframer_unit #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // byte input
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_data_byte,
    // payload output
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [7:0]                    o_record_id,
    output logic [7:0]                    o_byte_index,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_last_byte,
    output sdld_pkg::t_fmt_status         o_format_status,
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire sdld_pkg::t_cfg_index     i_cfg_index,
    input  wire logic [7:0]               i_cfg_data
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [8:0] TABLE_LIMIT = 9'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_ID,
        PH_DATA
    } t_phase;

    // configuration
    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_format_id;

    // length memory and known bits
    logic [7:0]               r_len_mem [TABLE_ENTRIES];
    logic [7:0]               r_rd_len;
    logic [TABLE_ENTRIES-1:0] r_known;

    // staging register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    // record state
    t_phase     r_phase,     n_phase;
    logic [7:0] r_cur_id,    n_cur_id;
    logic [7:0] r_exp_cnt,   n_exp_cnt;
    logic [7:0] r_rcv_cnt,   n_rcv_cnt;
    logic [7:0] r_ptype,     n_ptype;
    logic [7:0] r_plen,      n_plen;
    logic [4:0] r_spec_cnt,  n_spec_cnt;
    logic       r_spec_end,  n_spec_end;
    logic [5:0] r_lab_cnt,   n_lab_cnt;
    logic       r_in_label,  n_in_label;
    logic       r_lab_end,   n_lab_end;

    // output register
    logic                  r_out_valid;
    logic [7:0]            r_out_id;
    logic [7:0]            r_out_idx;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    sdld_pkg::t_fmt_status r_out_status;

    logic                  out_free;
    logic                  s1_data;
    logic                  s1_go;
    logic                  in_accept;
    logic                  res_last;
    sdld_pkg::t_fmt_status res_status;
    logic                  wr_en;
    logic                  fmt_ok;
    logic                  is_fmt;
    logic [7:0]            b;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_data    = (r_phase == PH_DATA);
    assign s1_go      = r_s1_valid && (!s1_data || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign b          = r_s1_byte;
    assign is_fmt     = (r_cur_id == r_format_id);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= sdld_pkg::SYNC_FIRST_RESET;
            r_sync_second <= sdld_pkg::SYNC_SECOND_RESET;
            r_format_id   <= sdld_pkg::FORMAT_RECORD_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sdld_pkg::CFG_SYNC_FIRST:       r_sync_first  <= i_cfg_data;
                sdld_pkg::CFG_SYNC_SECOND:      r_sync_second <= i_cfg_data;
                sdld_pkg::CFG_FORMAT_RECORD_ID: r_format_id   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // process the staged byte against the record state
    always_comb begin
        n_phase    = r_phase;
        n_cur_id   = r_cur_id;
        n_exp_cnt  = r_exp_cnt;
        n_rcv_cnt  = r_rcv_cnt;
        n_ptype    = r_ptype;
        n_plen     = r_plen;
        n_spec_cnt = r_spec_cnt;
        n_spec_end = r_spec_end;
        n_lab_cnt  = r_lab_cnt;
        n_in_label = r_in_label;
        n_lab_end  = r_lab_end;
        res_last   = 1'b0;
        res_status = sdld_pkg::STATUS_NONE;
        wr_en      = 1'b0;
        fmt_ok     = 1'b0;

        unique case (r_phase)
            PH_FIRST: begin
                if (b == r_sync_first) n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                // hold here on a wrong second byte
                if (b == r_sync_second) n_phase = PH_ID;
            end
            PH_ID: begin
                n_cur_id   = b;
                n_rcv_cnt  = 8'd0;
                n_ptype    = 8'd0;
                n_plen     = 8'd0;
                n_spec_cnt = 5'd0;
                n_spec_end = 1'b0;
                n_lab_cnt  = 6'd0;
                n_in_label = 1'b0;
                n_lab_end  = 1'b0;
                if (b == r_format_id) begin
                    n_exp_cnt = sdld_pkg::FORMAT_RECORD_BYTES;
                    n_phase   = PH_DATA;
                end else if (({1'b0, b} < TABLE_LIMIT) && r_known[b[AW-1:0]]) begin
                    n_exp_cnt = r_rd_len;
                    n_phase   = PH_DATA;
                end else begin
                    // drop the frame
                    n_phase = PH_FIRST;
                end
            end
            PH_DATA: begin
                if (is_fmt) begin
                    if (r_rcv_cnt == sdld_pkg::POS_TYPE) begin
                        n_ptype = b;
                    end else if (r_rcv_cnt == sdld_pkg::POS_LENGTH) begin
                        n_plen = b;
                    end else if (r_rcv_cnt >= sdld_pkg::SPEC_START &&
                                 r_rcv_cnt < sdld_pkg::LABEL_START) begin
                        if (!r_spec_end) begin
                            if (b == sdld_pkg::CHAR_NUL)
                                n_spec_end = 1'b1;
                            else if (r_spec_cnt < sdld_pkg::SPEC_CNT_MAX)
                                n_spec_cnt = r_spec_cnt + 5'd1;
                        end
                    end else if (r_rcv_cnt >= sdld_pkg::LABEL_START &&
                                 r_rcv_cnt < sdld_pkg::LABEL_END) begin
                        if (!r_lab_end) begin
                            if (b == sdld_pkg::CHAR_NUL) begin
                                n_lab_end  = 1'b1;
                                n_in_label = 1'b0;
                            end else if (b == sdld_pkg::CHAR_COMMA) begin
                                n_in_label = 1'b0;
                            end else if (!r_in_label) begin
                                n_in_label = 1'b1;
                                if (r_lab_cnt < sdld_pkg::LABEL_CNT_MAX)
                                    n_lab_cnt = r_lab_cnt + 6'd1;
                            end
                        end
                    end
                end

                res_last = ({1'b0, r_rcv_cnt} + 9'd1) >= {1'b0, r_exp_cnt};
                fmt_ok   = (n_plen != 8'd0) && (n_spec_cnt != 5'd0) &&
                           (n_lab_cnt != 6'd0) &&
                           (n_lab_cnt == {1'b0, n_spec_cnt});

                if (res_last) begin
                    n_phase   = PH_FIRST;
                    n_rcv_cnt = 8'd0;
                    if (is_fmt) begin
                        if (fmt_ok && ({1'b0, n_ptype} < TABLE_LIMIT)) begin
                            res_status = sdld_pkg::STATUS_STORED;
                            wr_en      = 1'b1;
                        end else begin
                            res_status = sdld_pkg::STATUS_REJECTED;
                        end
                    end
                end else begin
                    n_rcv_cnt = r_rcv_cnt + 8'd1;
                end
            end
            default: n_phase = PH_FIRST;
        endcase
    end

    // length memory: read at the incoming byte, write on a stored format.
    // An id read is at least three beats behind any write, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (s1_go && wr_en)
            r_len_mem[n_ptype[AW-1:0]] <= n_plen;
        if (in_accept)
            r_rd_len <= r_len_mem[i_data_byte[AW-1:0]];
    end

    // state, staging and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_cur_id    <= 8'd0;
            r_exp_cnt   <= 8'd0;
            r_rcv_cnt   <= 8'd0;
            r_ptype     <= 8'd0;
            r_plen      <= 8'd0;
            r_spec_cnt  <= 5'd0;
            r_spec_end  <= 1'b0;
            r_lab_cnt   <= 6'd0;
            r_in_label  <= 1'b0;
            r_lab_end   <= 1'b0;
            r_known     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_byte  <= i_data_byte;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_phase    <= n_phase;
                r_cur_id   <= n_cur_id;
                r_exp_cnt  <= n_exp_cnt;
                r_rcv_cnt  <= n_rcv_cnt;
                r_ptype    <= n_ptype;
                r_plen     <= n_plen;
                r_spec_cnt <= n_spec_cnt;
                r_spec_end <= n_spec_end;
                r_lab_cnt  <= n_lab_cnt;
                r_in_label <= n_in_label;
                r_lab_end  <= n_lab_end;
                if (wr_en)
                    r_known[n_ptype[AW-1:0]] <= 1'b1;
            end

            if (s1_go && s1_data) begin
                r_out_valid  <= 1'b1;
                r_out_id     <= r_cur_id;
                r_out_idx    <= r_rcv_cnt;
                r_out_byte   <= b;
                r_out_last   <= res_last;
                r_out_status <= res_status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_record_id     = r_out_id;
    assign o_byte_index    = r_out_idx;
    assign o_payload_byte  = r_out_byte;
    assign o_last_byte     = r_out_last;
    assign o_format_status = r_out_status;

endmodule

`default_nettype wire
